// ===== sv/pscsg_pkg.sv =====
// Shared widths, reset values and defaults for the per-source shot gate.
// No dependencies; compile this file first.
package pscsg_pkg;

   // Payload field widths
   localparam int SOURCE_ID_W = 32;
   localparam int TIME_W      = 32;
   localparam int RATIO_W     = 17;
   localparam int SLOT_USED_W = 4;

   // Credit is Q1.16; ratios that reach the table are Q0.16
   localparam int FRAC_W   = 16;
   localparam int CREDIT_W = FRAC_W + 1;

   // Burst gap register
   localparam int              GAP_W     = 16;
   localparam logic [GAP_W-1:0] GAP_RESET = 16'd200;

   // Parameter defaults
   localparam int SLOT_COUNT_DEF  = 16;
   localparam int SOURCE_BITS_DEF = 32;

endpackage

// ===== sv/pscsg_if.sv =====
// Valid/ready channel interfaces for requests and responses of the shot gate.
// Depends on pscsg_pkg for the field widths.
interface pscsg_req_if;
   import pscsg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SOURCE_ID_W-1:0] source_id;
   logic [TIME_W-1:0]      now_ms;
   logic [RATIO_W-1:0]     step_ratio;

   modport source (output valid, source_id, now_ms, step_ratio, input ready);
   modport sink   (input valid, source_id, now_ms, step_ratio, output ready);
endinterface

interface pscsg_rsp_if;
   import pscsg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   allowed;
   logic [SLOT_USED_W-1:0] slot_used;

   modport source (output valid, allowed, slot_used, input ready);
   modport sink   (input valid, allowed, slot_used, output ready);
endinterface

// ===== sv/pscsg_slot_mem.sv =====
// Slot table storage: one write port, one read port, registered read data.
// No package dependency; sized by the top level.
module pscsg_slot_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 81,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read: the entry appears on rd_data in the cycle after rd_en
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/per_source_credit_shot_gate_core.sv =====
// Per-source shot gate: slot search over a table memory, credit update, write-back.
// Depends on pscsg_pkg, pscsg_req_if / pscsg_rsp_if and pscsg_slot_mem.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------------
//   req_ch   | in  | valid / ready    | source_id[31:0] now_ms[31:0] step_ratio[16:0]
//   rsp_ch   | out | valid / ready    | allowed slot_used[3:0]
//   csr      | in  | csr_wr_en        | csr_wr_data[15:0] (burst_gap_ms)
//
// A request whose ratio is zero or one and above skips the scan and goes straight
// to the update state. Other requests scan the table one slot per cycle through the
// read port of the slot memory and stop at the first slot that matches or is free.
// One request is in work at a time.
// Reset clears the valid bits, the burst gap (to 200) and all control state.
// A finished result waits in the output register; a new request is taken
// meanwhile, and the update stage holds while the output register is full and not taken.
module per_source_credit_shot_gate_core #(
   parameter int SLOT_COUNT  = pscsg_pkg::SLOT_COUNT_DEF,
   parameter int SOURCE_BITS = pscsg_pkg::SOURCE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   pscsg_req_if.sink                     req_ch,
   pscsg_rsp_if.source                   rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [pscsg_pkg::GAP_W-1:0]   csr_wr_data
);
   import pscsg_pkg::*;

   localparam int IDX_W   = $clog2(SLOT_COUNT);
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W = SOURCE_BITS + TIME_W + CREDIT_W;
   localparam int PAD_W   = (IDX_W > SLOT_USED_W) ? IDX_W : SLOT_USED_W;

   localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOT_COUNT - 1);
   localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(SLOT_COUNT);

   // Control states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   // How the chosen slot is handled
   localparam logic [1:0] KIND_BYPASS = 2'd0;
   localparam logic [1:0] KIND_NEW    = 2'd1;
   localparam logic [1:0] KIND_MATCH  = 2'd2;

   // Control registers
   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GAP_W-1:0]      gap_ff, gap_in;

   // Payload registers
   logic [SOURCE_BITS-1:0] src_ff, src_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic [FRAC_W-1:0]      ratio_ff, ratio_in;
   logic [IDX_W-1:0]       oldest_idx_ff, oldest_idx_in;
   logic [TIME_W-1:0]      oldest_time_ff, oldest_time_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [1:0]             kind_ff, kind_in;
   logic [TIME_W-1:0]      hit_time_ff, hit_time_in;
   logic [CREDIT_W-1:0]    hit_credit_ff, hit_credit_in;
   logic                   rsp_allowed_ff, rsp_allowed_in;
   logic [SLOT_USED_W-1:0] rsp_slot_ff, rsp_slot_in;

   // Memory ports
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_addr;
   logic [ENTRY_W-1:0]     mem_wr_data;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   logic [ENTRY_W-1:0]     mem_rd_data;

   // Fields of the entry under compare
   logic [SOURCE_BITS-1:0] rd_source;
   logic [TIME_W-1:0]      rd_time;
   logic [CREDIT_W-1:0]    rd_credit;

   // Request decode
   logic                   req_xfer;
   logic                   req_bypass;
   logic [63:0]            src_wide;

   // Scan and update helpers
   logic                   slot_v;
   logic                   older;
   logic [TIME_W-1:0]      older_diff;
   logic                   out_free;
   logic                   update_fire;
   logic [TIME_W-1:0]      idle_gap;
   logic                   stale;
   logic                   renew;
   logic [CREDIT_W-1:0]    sum;
   logic [CREDIT_W-1:0]    new_credit;
   logic                   upd_allowed;
   logic [PAD_W-1:0]       slot_wide;

   pscsg_slot_mem #(
      .DEPTH  (SLOT_COUNT),
      .WIDTH  (ENTRY_W),
      .ADDR_W (IDX_W)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_source = mem_rd_data[ENTRY_W-1 -: SOURCE_BITS];
   assign rd_time   = mem_rd_data[CREDIT_W +: TIME_W];
   assign rd_credit = mem_rd_data[CREDIT_W-1:0];

   // Request side: take a new request only between items
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_bypass   = (req_ch.step_ratio == '0) || req_ch.step_ratio[FRAC_W];
   assign src_wide     = 64'(req_ch.source_id);

   // Scan: issue one read per cycle, compare the slot read in the previous cycle
   assign mem_rd_en   = (state_ff == ST_SCAN) && (rd_cnt_ff < CNT_END);
   assign mem_rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign slot_v      = valid_ff[cmp_idx_ff];
   assign older_diff  = rd_time - oldest_time_ff;
   assign older       = (cmp_idx_ff == '0) || older_diff[TIME_W-1];

   // Update: staleness and credit
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign update_fire = (state_ff == ST_UPDATE) && out_free;
   assign idle_gap    = now_ff - hit_time_ff;
   assign stale       = idle_gap > TIME_W'(gap_ff);
   assign renew       = (kind_ff == KIND_NEW) || stale;
   assign sum         = hit_credit_ff + CREDIT_W'(ratio_ff);
   assign new_credit  = renew ? '0 : {1'b0, sum[FRAC_W-1:0]};
   assign upd_allowed = renew || sum[FRAC_W];
   assign slot_wide   = PAD_W'(hit_idx_ff);

   assign mem_wr_en   = update_fire && (kind_ff != KIND_BYPASS);
   assign mem_wr_addr = hit_idx_ff;
   assign mem_wr_data = {src_ff, now_ff, new_credit};

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = mem_rd_addr;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      gap_in         = csr_wr_en ? csr_wr_data : gap_ff;
      src_in         = src_ff;
      now_in         = now_ff;
      ratio_in       = ratio_ff;
      oldest_idx_in  = oldest_idx_ff;
      oldest_time_in = oldest_time_ff;
      hit_idx_in     = hit_idx_ff;
      kind_in        = kind_ff;
      hit_time_in    = hit_time_ff;
      hit_credit_in  = hit_credit_ff;
      rsp_allowed_in = rsp_allowed_ff;
      rsp_slot_in    = rsp_slot_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               src_in    = src_wide[SOURCE_BITS-1:0];
               now_in    = req_ch.now_ms;
               ratio_in  = req_ch.step_ratio[FRAC_W-1:0];
               rd_cnt_in = '0;
               if (req_bypass) begin
                  kind_in  = KIND_BYPASS;
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (mem_rd_en) begin
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff) begin
               if (!slot_v) begin
                  // Free slot: take it
                  hit_idx_in = cmp_idx_ff;
                  kind_in    = KIND_NEW;
                  cmp_vld_in = 1'b0;
                  state_in   = ST_UPDATE;
               end else if (rd_source == src_ff) begin
                  // Own slot: hold its time and credit for the update
                  hit_idx_in    = cmp_idx_ff;
                  kind_in       = KIND_MATCH;
                  hit_time_in   = rd_time;
                  hit_credit_in = rd_credit;
                  cmp_vld_in    = 1'b0;
                  state_in      = ST_UPDATE;
               end else begin
                  // Track the oldest slot; replace it after the last one
                  if (older) begin
                     oldest_idx_in  = cmp_idx_ff;
                     oldest_time_in = rd_time;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     hit_idx_in = older ? cmp_idx_ff : oldest_idx_ff;
                     kind_in    = KIND_NEW;
                     cmp_vld_in = 1'b0;
                     state_in   = ST_UPDATE;
                  end
               end
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (kind_ff == KIND_BYPASS) begin
                  rsp_allowed_in = 1'b1;
                  rsp_slot_in    = '0;
               end else begin
                  rsp_allowed_in       = upd_allowed;
                  rsp_slot_in          = slot_wide[SLOT_USED_W-1:0];
                  valid_in[hit_idx_ff] = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         gap_ff       <= GAP_RESET;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         gap_ff       <= gap_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff     <= cmp_idx_in;
      src_ff         <= src_in;
      now_ff         <= now_in;
      ratio_ff       <= ratio_in;
      oldest_idx_ff  <= oldest_idx_in;
      oldest_time_ff <= oldest_time_in;
      hit_idx_ff     <= hit_idx_in;
      kind_ff        <= kind_in;
      hit_time_ff    <= hit_time_in;
      hit_credit_ff  <= hit_credit_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_slot_ff    <= rsp_slot_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.allowed   = rsp_allowed_ff;
   assign rsp_ch.slot_used = rsp_slot_ff;

`ifndef SYNTHESIS
   // A bypassed request always allows and reports slot zero
   a_bypass_result: assert property (@(posedge clock) disable iff (reset)
      (update_fire && kind_ff == KIND_BYPASS) |=> (rsp_ch.allowed && rsp_ch.slot_used == '0))
      else $error("bypass result is not allow on slot zero");

   // Stored credit stays below one after every write-back
   a_credit_below_one: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !mem_wr_data[FRAC_W])
      else $error("credit written back at or above one");

   // A written slot is marked valid afterwards
   a_written_slot_valid: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> valid_ff[$past(mem_wr_addr)])
      else $error("written slot not marked valid");

   // No request is taken while one is still in the scan or update
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_UPDATE) |-> !req_ch.ready)
      else $error("request taken while another is in work");
`endif

endmodule
